// File: sv/fgde_pkg.sv
// Shared types, constants and helper functions of the flat geodesic derivative unit.
package fgde_pkg;

	localparam int RED_STEPS = 13;
	localparam int ROT_W = 34;
	localparam int DIV_LAT = 32;

	localparam logic [32:0] Q30_TWO_PI = 33'd6746518852;
	localparam logic [32:0] Q30_PI = 33'd3373259426;
	localparam logic [32:0] Q30_HALF_PI = 33'd1686629713;
	localparam logic [32:0] Q30_THREE_HALF_PI = 33'd5059889139;

	typedef struct packed {
		logic signed [31:0] radius;
		logic signed [31:0] polar_angle;
		logic signed [31:0] mom_time;
		logic signed [31:0] mom_radial;
		logic signed [31:0] mom_polar;
		logic signed [31:0] mom_azimuth;
	} fgde_in_t;

	typedef struct packed {
		logic signed [31:0] rate_time;
		logic signed [31:0] rate_radius;
		logic signed [31:0] rate_polar;
		logic signed [31:0] rate_azimuth;
		logic signed [31:0] rate_mom_radial;
		logic signed [31:0] rate_mom_polar;
		logic stop_flag;
		logic invalid_flag;
	} fgde_out_t;

	typedef struct packed {
		logic [31:0] rate_time;
		logic [31:0] rate_radius;
		logic neg_polar;
		logic neg_azimuth;
		logic neg_mom_radial;
		logic neg_mom_polar;
		logic stop_flag;
		logic invalid_flag;
	} fgde_side_t;

	typedef struct packed {
		logic [ROT_W-1:0] x;
		logic [ROT_W-1:0] y;
		logic [ROT_W-1:0] z;
		logic flip;
	} fgde_rot_t;

	function automatic logic [ROT_W-1:0] cordic_arc(input int i);
		logic [ROT_W-1:0] a;
		case (i)
			0: a = 34'd843314857;
			1: a = 34'd497837829;
			2: a = 34'd263043837;
			3: a = 34'd133525159;
			4: a = 34'd67021687;
			5: a = 34'd33543516;
			6: a = 34'd16775851;
			7: a = 34'd8388437;
			8: a = 34'd4194283;
			9: a = 34'd2097149;
			10: a = 34'd1048576;
			11: a = 34'd524288;
			12: a = 34'd262144;
			13: a = 34'd131072;
			14: a = 34'd65536;
			15: a = 34'd32768;
			16: a = 34'd16384;
			17: a = 34'd8192;
			18: a = 34'd4096;
			19: a = 34'd2048;
			20: a = 34'd1024;
			21: a = 34'd512;
			22: a = 34'd256;
			23: a = 34'd128;
			24: a = 34'd64;
			25: a = 34'd32;
			26: a = 34'd16;
			27: a = 34'd8;
			28: a = 34'd4;
			29: a = 34'd2;
			30: a = 34'd1;
			default: a = '0;
		endcase
		return a;
	endfunction

	function automatic logic [ROT_W-1:0] cordic_gain(input int steps);
		logic [ROT_W-1:0] g;
		case (steps)
			8: g = 34'd652039508;
			9: g = 34'd652034533;
			10: g = 34'd652033289;
			11: g = 34'd652032978;
			12: g = 34'd652032900;
			13: g = 34'd652032881;
			14: g = 34'd652032876;
			15: g = 34'd652032875;
			default: g = 34'd652032874;
		endcase
		return g;
	endfunction

	function automatic logic [31:0] sat_signed(input logic [31:0] mag, input logic neg);
		logic [31:0] v;
		if (mag[31]) begin
			v = neg ? 32'h8000_0000 : 32'h7fff_ffff;
		end else begin
			v = neg ? 32'(-mag) : mag;
		end
		return v;
	endfunction

endpackage

// File: sv/fgde_div.sv
// Pipelined restoring divider giving a 31-bit quotient, saturated to 2^31.
module fgde_div #(
	parameter int NW = 64,
	parameter int DW = 63
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [31:0]   quo
);
	import fgde_pkg::*;

	localparam int TW = NW - 31;
	localparam int MW = (TW > DW) ? TW : DW;

	logic [DW-1:0] rem_s [DIV_LAT-1];
	logic [DW-1:0] den_s [DIV_LAT-1];
	logic [30:0]   low_s [DIV_LAT-1];
	logic [30:0]   q_s   [DIV_LAT];
	logic          sat_s [DIV_LAT];
	logic          zr_s  [DIV_LAT];

	logic [TW-1:0] top;
	logic          sat0;

	assign top = num[NW-1:31];
	assign sat0 = (den == '0) ? (num != '0) : (MW'(top) >= MW'(den));

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= DW'(top);
			den_s[0] <= den;
			low_s[0] <= num[30:0];
			q_s[0] <= '0;
			sat_s[0] <= sat0;
			zr_s[0] <= (den == '0) && (num == '0);
		end
	end

	genvar k;
	for (k = 1; k < DIV_LAT; k++) begin : g_step
		logic [DW:0] t;
		logic [DW:0] diff;
		logic ge;
		assign t = {rem_s[k-1], low_s[k-1][30]};
		assign diff = t - {1'b0, den_s[k-1]};
		assign ge = t >= {1'b0, den_s[k-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				q_s[k] <= {q_s[k-1][29:0], ge};
				sat_s[k] <= sat_s[k-1];
				zr_s[k] <= zr_s[k-1];
			end
		end
		if (k < DIV_LAT - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? diff[DW-1:0] : t[DW-1:0];
					den_s[k] <= den_s[k-1];
					low_s[k] <= {low_s[k-1][29:0], 1'b0};
				end
			end
		end
	end

	assign quo = sat_s[DIV_LAT-1] ? 32'h8000_0000 :
		(zr_s[DIV_LAT-1] ? 32'd0 : {1'b0, q_s[DIV_LAT-1]});

endmodule

// File: sv/flat_geodesic_derivative_eval_unit.sv
// Top level of the flat-spacetime geodesic derivative pipeline.
// One transaction enters per cycle unless the pipeline holds, and passes through 13 angle
// reduction stages, 2 fold stages, one stage per CORDIC step, 2 stages for rounding and
// magnitudes, 5 multiplier stages, 32 divider stages and the output register. The whole
// pipeline holds while a finished result waits on out_ready.
module flat_geodesic_derivative_eval_unit #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  fgde_pkg::fgde_in_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output fgde_pkg::fgde_out_t out_data,
	input  logic               cfg_we,
	input  logic [30:0]        cfg_wdata
);
	import fgde_pkg::*;

	localparam int STEPS = (CORDIC_STEPS < 8) ? 8 : ((CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS);
	localparam int NSTG = RED_STEPS + 2 + STEPS + 2 + 5 + DIV_LAT + 1;

	logic en;
	logic [NSTG-1:0] vld_q;
	logic [30:0] esc_q;

	assign en = !out_valid || out_ready;
	assign in_ready = en;
	assign out_valid = vld_q[NSTG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			esc_q <= 31'd1966080;
		end else begin
			if (en) vld_q <= {vld_q[NSTG-2:0], in_valid};
			if (cfg_we) esc_q <= cfg_wdata;
		end
	end

	// angle reduction modulo two pi
	logic [45:0] ang_v;
	logic [45:0] ang_mag;
	assign ang_v = {in_data.polar_angle, 14'd0};
	assign ang_mag = in_data.polar_angle[31] ? 46'(-ang_v) : ang_v;

	logic [45:0] red_rem_s  [RED_STEPS];
	logic        red_neg_s  [RED_STEPS];
	fgde_in_t    red_item_s [RED_STEPS];

	genvar j;
	for (j = 0; j < RED_STEPS; j++) begin : g_red
		localparam logic [45:0] RC = 46'(Q30_TWO_PI) << (RED_STEPS - 1 - j);
		logic [45:0] prev_rem;
		logic        prev_neg;
		fgde_in_t    prev_item;
		if (j == 0) begin : g_first
			assign prev_rem = ang_mag;
			assign prev_neg = in_data.polar_angle[31];
			assign prev_item = in_data;
		end else begin : g_next
			assign prev_rem = red_rem_s[j-1];
			assign prev_neg = red_neg_s[j-1];
			assign prev_item = red_item_s[j-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				red_rem_s[j] <= (prev_rem >= RC) ? prev_rem - RC : prev_rem;
				red_neg_s[j] <= prev_neg;
				red_item_s[j] <= prev_item;
			end
		end
	end

	// fold into [-pi/2, pi/2]
	logic [32:0] m_red;
	logic [32:0] foa_z_s;
	fgde_in_t    foa_item_s;
	fgde_rot_t   fob_s;
	fgde_in_t    fob_item_s;
	logic [ROT_W-1:0] z0w;

	assign m_red = red_rem_s[RED_STEPS-1][32:0];
	assign z0w = {1'b0, foa_z_s};

	always_ff @(posedge clk) begin
		if (en) begin
			foa_z_s <= (red_neg_s[RED_STEPS-1] && m_red != '0) ? Q30_TWO_PI - m_red : m_red;
			foa_item_s <= red_item_s[RED_STEPS-1];
			fob_s.x <= cordic_gain(STEPS);
			fob_s.y <= '0;
			fob_item_s <= foa_item_s;
			if (foa_z_s < Q30_PI) begin
				fob_s.flip <= foa_z_s > Q30_HALF_PI;
				fob_s.z <= (foa_z_s > Q30_HALF_PI) ? z0w - {1'b0, Q30_PI} : z0w;
			end else begin
				fob_s.flip <= foa_z_s < Q30_THREE_HALF_PI;
				fob_s.z <= (foa_z_s < Q30_THREE_HALF_PI) ? z0w - {1'b0, Q30_PI}
					: z0w - {1'b0, Q30_TWO_PI};
			end
		end
	end

	// CORDIC rotation, one step per stage
	fgde_rot_t cor_s      [STEPS];
	fgde_in_t  cor_item_s [STEPS];

	genvar i;
	for (i = 0; i < STEPS; i++) begin : g_cor
		fgde_rot_t prev;
		fgde_in_t  prev_item;
		logic signed [ROT_W-1:0] px, py, pz, dx, dy;
		if (i == 0) begin : g_first
			assign prev = fob_s;
			assign prev_item = fob_item_s;
		end else begin : g_next
			assign prev = cor_s[i-1];
			assign prev_item = cor_item_s[i-1];
		end
		assign px = prev.x;
		assign py = prev.y;
		assign pz = prev.z;
		assign dx = py >>> i;
		assign dy = px >>> i;
		always_ff @(posedge clk) begin
			if (en) begin
				cor_item_s[i] <= prev_item;
				cor_s[i].flip <= prev.flip;
				if (!pz[ROT_W-1]) begin
					cor_s[i].x <= px - dx;
					cor_s[i].y <= py + dy;
					cor_s[i].z <= pz - cordic_arc(i);
				end else begin
					cor_s[i].x <= px + dx;
					cor_s[i].y <= py - dy;
					cor_s[i].z <= pz + cordic_arc(i);
				end
			end
		end
	end

	// round to Q16.16 and clamp
	logic signed [ROT_W-1:0] cx_f, cy_f, cx_r, cy_r, cx_c, cy_c;
	logic signed [17:0] q16_cos_s, q16_sin_s;
	fgde_in_t q16_item_s;

	assign cx_f = cor_s[STEPS-1].flip ? -$signed(cor_s[STEPS-1].x) : $signed(cor_s[STEPS-1].x);
	assign cy_f = cor_s[STEPS-1].flip ? -$signed(cor_s[STEPS-1].y) : $signed(cor_s[STEPS-1].y);
	assign cx_r = (cx_f + 34'sd8192) >>> 14;
	assign cy_r = (cy_f + 34'sd8192) >>> 14;
	assign cx_c = (cx_r > 34'sd65536) ? 34'sd65536 : ((cx_r < -34'sd65536) ? -34'sd65536 : cx_r);
	assign cy_c = (cy_r > 34'sd65536) ? 34'sd65536 : ((cy_r < -34'sd65536) ? -34'sd65536 : cy_r);

	always_ff @(posedge clk) begin
		if (en) begin
			q16_cos_s <= cx_c[17:0];
			q16_sin_s <= cy_c[17:0];
			q16_item_s <= cor_item_s[STEPS-1];
		end
	end

	// magnitudes, signs and flags
	logic [31:0] abs_ar_s, abs_aa_s, abs_ab_s;
	logic [16:0] abs_as_s, abs_ac_s;
	fgde_side_t  abs_side_s;
	logic [17:0] sin_neg, cos_neg;
	logic [31:0] rad_neg, pol_neg, azi_neg;

	assign sin_neg = -q16_sin_s;
	assign cos_neg = -q16_cos_s;
	assign rad_neg = -q16_item_s.radius;
	assign pol_neg = -q16_item_s.mom_polar;
	assign azi_neg = -q16_item_s.mom_azimuth;

	always_ff @(posedge clk) begin
		if (en) begin
			abs_ar_s <= q16_item_s.radius[31] ? rad_neg : q16_item_s.radius;
			abs_aa_s <= q16_item_s.mom_polar[31] ? pol_neg : q16_item_s.mom_polar;
			abs_ab_s <= q16_item_s.mom_azimuth[31] ? azi_neg : q16_item_s.mom_azimuth;
			abs_as_s <= q16_sin_s[17] ? sin_neg[16:0] : q16_sin_s[16:0];
			abs_ac_s <= q16_cos_s[17] ? cos_neg[16:0] : q16_cos_s[16:0];
			abs_side_s.rate_time <= (q16_item_s.mom_time == 32'sh8000_0000) ? 32'h7fff_ffff
				: 32'(-q16_item_s.mom_time);
			abs_side_s.rate_radius <= q16_item_s.mom_radial;
			abs_side_s.neg_polar <= q16_item_s.mom_polar[31];
			abs_side_s.neg_azimuth <= q16_item_s.mom_azimuth[31];
			abs_side_s.neg_mom_radial <= q16_item_s.radius[31];
			abs_side_s.neg_mom_polar <= q16_cos_s[17] != q16_sin_s[17];
			abs_side_s.stop_flag <= ($signed(q16_item_s.radius) > $signed({1'b0, esc_q}))
				&& q16_item_s.mom_radial[31];
			abs_side_s.invalid_flag <= (q16_item_s.radius == '0) || (q16_sin_s == '0);
		end
	end

	// M1: squares
	logic [63:0] r2_f, aa2_f, ab2_f;
	logic [33:0] s2_f;
	logic [62:0] m1_r2_s, m1_aa2_s, m1_ab2_s;
	logic [32:0] m1_s2_s;
	logic [31:0] m1_ar_s, m1_aa_s, m1_ab_s;
	logic [16:0] m1_as_s, m1_ac_s;
	fgde_side_t  m1_side_s;

	assign r2_f = abs_ar_s * abs_ar_s;
	assign aa2_f = abs_aa_s * abs_aa_s;
	assign ab2_f = abs_ab_s * abs_ab_s;
	assign s2_f = abs_as_s * abs_as_s;

	always_ff @(posedge clk) begin
		if (en) begin
			m1_r2_s <= r2_f[62:0];
			m1_aa2_s <= aa2_f[62:0];
			m1_ab2_s <= ab2_f[62:0];
			m1_s2_s <= s2_f[32:0];
			m1_ar_s <= abs_ar_s;
			m1_aa_s <= abs_aa_s;
			m1_ab_s <= abs_ab_s;
			m1_as_s <= abs_as_s;
			m1_ac_s <= abs_ac_s;
			m1_side_s <= abs_side_s;
		end
	end

	// M2: partial products
	logic [64:0] pr_lo_f, ps_lo_f;
	logic [63:0] pr_hi_f, ps_hi_f;
	logic [48:0] pc_lo_f;
	logic [47:0] pc_hi_f;
	logic [64:0] m2_pr_lo_s, m2_ps_lo_s;
	logic [63:0] m2_pr_hi_s, m2_ps_hi_s;
	logic [48:0] m2_pc_lo_s;
	logic [47:0] m2_pc_hi_s;
	logic [62:0] m2_r2_s, m2_ab2_s;
	logic [31:0] m2_ar_s, m2_aa_s, m2_ab_s;
	logic [16:0] m2_as_s;
	fgde_side_t  m2_side_s;

	assign pr_lo_f = m1_r2_s[31:0] * m1_s2_s;
	assign pr_hi_f = m1_r2_s[62:32] * m1_s2_s;
	assign ps_lo_f = m1_aa2_s[31:0] * m1_s2_s;
	assign ps_hi_f = m1_aa2_s[62:32] * m1_s2_s;
	assign pc_lo_f = m1_ab2_s[31:0] * m1_ac_s;
	assign pc_hi_f = m1_ab2_s[62:32] * m1_ac_s;

	always_ff @(posedge clk) begin
		if (en) begin
			m2_pr_lo_s <= pr_lo_f;
			m2_pr_hi_s <= pr_hi_f;
			m2_ps_lo_s <= ps_lo_f;
			m2_ps_hi_s <= ps_hi_f;
			m2_pc_lo_s <= pc_lo_f;
			m2_pc_hi_s <= pc_hi_f;
			m2_r2_s <= m1_r2_s;
			m2_ab2_s <= m1_ab2_s;
			m2_ar_s <= m1_ar_s;
			m2_aa_s <= m1_aa_s;
			m2_ab_s <= m1_ab_s;
			m2_as_s <= m1_as_s;
			m2_side_s <= m1_side_s;
		end
	end

	// M3: combine partials
	logic [95:0] rs2_f, ts_f;
	logic [79:0] tc_f;
	logic [94:0] m3_rs2_s, m3_ts_s;
	logic [78:0] m3_tc_s;
	logic [62:0] m3_r2_s, m3_ab2_s;
	logic [31:0] m3_ar_s, m3_aa_s, m3_ab_s;
	logic [16:0] m3_as_s;
	fgde_side_t  m3_side_s;

	assign rs2_f = (96'(m2_pr_hi_s) << 32) + 96'(m2_pr_lo_s);
	assign ts_f = (96'(m2_ps_hi_s) << 32) + 96'(m2_ps_lo_s);
	assign tc_f = (80'(m2_pc_hi_s) << 32) + 80'(m2_pc_lo_s);

	always_ff @(posedge clk) begin
		if (en) begin
			m3_rs2_s <= rs2_f[94:0];
			m3_ts_s <= ts_f[94:0];
			m3_tc_s <= tc_f[78:0];
			m3_r2_s <= m2_r2_s;
			m3_ab2_s <= m2_ab2_s;
			m3_ar_s <= m2_ar_s;
			m3_aa_s <= m2_aa_s;
			m3_ab_s <= m2_ab_s;
			m3_as_s <= m2_as_s;
			m3_side_s <= m2_side_s;
		end
	end

	// M4: divisor partials, radial numerator sum
	logic [63:0] pd4_0_f, pd4_1_f;
	logic [62:0] pd4_2_f;
	logic [48:0] pd5_0_f, pd5_1_f;
	logic [47:0] pd5_2_f;
	logic [95:0] n4_f;
	logic [63:0] m4_pd4_0_s, m4_pd4_1_s;
	logic [62:0] m4_pd4_2_s;
	logic [48:0] m4_pd5_0_s, m4_pd5_1_s;
	logic [47:0] m4_pd5_2_s;
	logic [95:0] m4_n4_s;
	logic [78:0] m4_tc_s;
	logic [94:0] m4_rs2_s;
	logic [62:0] m4_r2_s;
	logic [31:0] m4_aa_s, m4_ab_s;
	fgde_side_t  m4_side_s;

	assign pd4_0_f = m3_rs2_s[31:0] * m3_ar_s;
	assign pd4_1_f = m3_rs2_s[63:32] * m3_ar_s;
	assign pd4_2_f = m3_rs2_s[94:64] * m3_ar_s;
	assign pd5_0_f = m3_rs2_s[31:0] * m3_as_s;
	assign pd5_1_f = m3_rs2_s[63:32] * m3_as_s;
	assign pd5_2_f = m3_rs2_s[94:64] * m3_as_s;
	assign n4_f = 96'(m3_ts_s) + (96'(m3_ab2_s) << 32);

	always_ff @(posedge clk) begin
		if (en) begin
			m4_pd4_0_s <= pd4_0_f;
			m4_pd4_1_s <= pd4_1_f;
			m4_pd4_2_s <= pd4_2_f;
			m4_pd5_0_s <= pd5_0_f;
			m4_pd5_1_s <= pd5_1_f;
			m4_pd5_2_s <= pd5_2_f;
			m4_n4_s <= n4_f;
			m4_tc_s <= m3_tc_s;
			m4_rs2_s <= m3_rs2_s;
			m4_r2_s <= m3_r2_s;
			m4_aa_s <= m3_aa_s;
			m4_ab_s <= m3_ab_s;
			m4_side_s <= m3_side_s;
		end
	end

	// M5: divider operands
	logic [127:0] d4_f, d5_f;
	logic [63:0]  m5_n2_s;
	logic [62:0]  m5_d2_s;
	logic [95:0]  m5_n3_s;
	logic [94:0]  m5_d3_s;
	logic [127:0] m5_n4_s;
	logic [125:0] m5_d4_s;
	logic [126:0] m5_n5_s;
	logic [110:0] m5_d5_s;
	fgde_side_t   m5_side_s;

	assign d4_f = 128'(m4_pd4_0_s) + (128'(m4_pd4_1_s) << 32) + (128'(m4_pd4_2_s) << 64);
	assign d5_f = 128'(m4_pd5_0_s) + (128'(m4_pd5_1_s) << 32) + (128'(m4_pd5_2_s) << 64);

	always_ff @(posedge clk) begin
		if (en) begin
			m5_n2_s <= {m4_aa_s, 32'd0};
			m5_d2_s <= m4_r2_s;
			m5_n3_s <= {m4_ab_s, 64'd0};
			m5_d3_s <= m4_rs2_s;
			m5_n4_s <= {m4_n4_s, 32'd0};
			m5_d4_s <= d4_f[125:0];
			m5_n5_s <= {m4_tc_s, 48'd0};
			m5_d5_s <= d5_f[110:0];
			m5_side_s <= m4_side_s;
		end
	end

	// dividers and side delay line
	logic [31:0] q_polar, q_azimuth, q_mom_radial, q_mom_polar;
	fgde_side_t side_s [DIV_LAT];

	fgde_div #(.NW(64), .DW(63)) u_div_polar (
		.clk(clk), .en(en), .num(m5_n2_s), .den(m5_d2_s), .quo(q_polar)
	);
	fgde_div #(.NW(96), .DW(95)) u_div_azimuth (
		.clk(clk), .en(en), .num(m5_n3_s), .den(m5_d3_s), .quo(q_azimuth)
	);
	fgde_div #(.NW(128), .DW(126)) u_div_mom_radial (
		.clk(clk), .en(en), .num(m5_n4_s), .den(m5_d4_s), .quo(q_mom_radial)
	);
	fgde_div #(.NW(127), .DW(111)) u_div_mom_polar (
		.clk(clk), .en(en), .num(m5_n5_s), .den(m5_d5_s), .quo(q_mom_polar)
	);

	genvar k;
	for (k = 0; k < DIV_LAT; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (en) side_s[k] <= (k == 0) ? m5_side_s : side_s[(k == 0) ? 0 : k-1];
		end
	end

	// output register
	fgde_out_t out_q;
	fgde_side_t side_last;
	assign side_last = side_s[DIV_LAT-1];

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.rate_time <= side_last.rate_time;
			out_q.rate_radius <= side_last.rate_radius;
			out_q.rate_polar <= sat_signed(q_polar, side_last.neg_polar);
			out_q.rate_azimuth <= sat_signed(q_azimuth, side_last.neg_azimuth);
			out_q.rate_mom_radial <= sat_signed(q_mom_radial, side_last.neg_mom_radial);
			out_q.rate_mom_polar <= sat_signed(q_mom_polar, side_last.neg_mom_polar);
			out_q.stop_flag <= side_last.stop_flag;
			out_q.invalid_flag <= side_last.invalid_flag;
		end
	end

	assign out_data = out_q;

	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	a_stop_inward: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.stop_flag |-> out_data.rate_radius[31])
		else $error("stop flag without inward motion");

	a_invalid_azimuth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.invalid_flag |->
		(out_data.rate_azimuth == 32'sd0) || (out_data.rate_azimuth == 32'sh7fff_ffff) ||
		(out_data.rate_azimuth == 32'sh8000_0000))
		else $error("invalid transaction with unsaturated azimuth rate");

endmodule
